FILE: sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define SBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SBE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/sbe_pkg.sv
package sbe_pkg;

  localparam int CRD_W  = 14;
  localparam int PIX_W  = 12;
  localparam int CH_W   = 8;
  localparam int PRES_W = 8;
  localparam int SIZE_W = 10;
  localparam int PCT_W  = 7;
  localparam int Q_W    = 17;

  localparam logic [Q_W-1:0] Q_ONE      = 17'h10000;
  // one plus the 0.001 epsilon (66 in Q1.16)
  localparam logic [Q_W-1:0] H_DEN_BASE = 17'd65602;
  // ceil(2^26 / 25): exact reciprocal for pct * 16384 / 25
  localparam logic [42:0]    PCT_RECIP  = 43'd2684355;

  typedef enum logic [1:0] {
    REG_DAB_SIZE = 2'd0,
    REG_OPACITY  = 2'd1,
    REG_HARDNESS = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pix_t;

  typedef struct packed {
    logic           hit;
    pix_t           pix;
    logic [Q_W-1:0] po;
  } side_t;

  // floor(min(pct,100) * 65536 / 100)
  function automatic logic [Q_W-1:0] pct_to_q(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0] c;
    logic [42:0]      prod;
    c    = (pct > 7'd100) ? 7'd100 : pct;
    prod = 43'({c, 14'd0}) * PCT_RECIP;
    return prod[42:26];
  endfunction

  // floor(pres * 65536 / 255) = pres * 257 + (pres == 255)
  function automatic logic [Q_W-1:0] pres_to_q(input logic [PRES_W-1:0] pres);
    return 17'({9'd0, pres} * 17'd257) + 17'(pres == 8'hFF);
  endfunction

endpackage

FILE: sv/sbe_in_if.sv
interface sbe_in_if;
  import sbe_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CRD_W-1:0]  center_x;
  logic signed [CRD_W-1:0]  center_y;
  logic [PRES_W-1:0]        pen_pressure;
  logic [PIX_W-1:0]         pixel_x;
  logic [PIX_W-1:0]         pixel_y;
  logic [CH_W-1:0]          old_red;
  logic [CH_W-1:0]          old_green;
  logic [CH_W-1:0]          old_blue;
  logic [CH_W-1:0]          old_alpha;

  modport source (
    output valid, center_x, center_y, pen_pressure, pixel_x, pixel_y,
           old_red, old_green, old_blue, old_alpha,
    input  ready
  );

  modport sink (
    input  valid, center_x, center_y, pen_pressure, pixel_x, pixel_y,
           old_red, old_green, old_blue, old_alpha,
    output ready
  );
endinterface

FILE: sv/sbe_out_if.sv
interface sbe_out_if;
  import sbe_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] new_red;
  logic [CH_W-1:0] new_green;
  logic [CH_W-1:0] new_blue;
  logic [CH_W-1:0] new_alpha;
  logic            touched;

  modport source (
    output valid, new_red, new_green, new_blue, new_alpha, touched,
    input  ready
  );

  modport sink (
    input  valid, new_red, new_green, new_blue, new_alpha, touched,
    output ready
  );
endinterface

FILE: sv/sbe_sqrt_pipe.sv
module sbe_sqrt_pipe #(
  parameter int RW = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2*RW-1:0]      in_value,
  input  sbe_pkg::side_t       in_side,
  output logic                 out_valid,
  output logic [RW-1:0]        out_root,
  output sbe_pkg::side_t       out_side
);
  import sbe_pkg::*;

  logic            vld_r  [RW];
  logic [2*RW-1:0] val_r  [RW];
  logic [RW:0]     rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  side_t           side_r [RW];

  logic            src_vld  [RW];
  logic [2*RW-1:0] src_val  [RW];
  logic [RW:0]     src_rem  [RW];
  logic [RW-1:0]   src_root [RW];
  side_t           src_side [RW];

  // one root bit per stage, two radicand bits enter each step
  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+2:0] sh;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign src_vld[k]  = in_valid;
      assign src_val[k]  = in_value;
      assign src_rem[k]  = '0;
      assign src_root[k] = '0;
      assign src_side[k] = in_side;
    end else begin : g_next
      assign src_vld[k]  = vld_r[k-1];
      assign src_val[k]  = val_r[k-1];
      assign src_rem[k]  = rem_r[k-1];
      assign src_root[k] = root_r[k-1];
      assign src_side[k] = side_r[k-1];
    end

    assign sh    = {src_rem[k], src_val[k][2*RW-1 -: 2]};
    assign trial = {1'b0, src_root[k], 2'b01};
    assign ge    = (sh >= trial);
    assign diff  = sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r[k]  <= {src_val[k][2*RW-3:0], 2'b00};
        rem_r[k]  <= ge ? diff[RW:0] : sh[RW:0];
        root_r[k] <= {src_root[k][RW-2:0], ge};
        side_r[k] <= src_side[k];
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

FILE: sv/sbe_div_pipe.sv
module sbe_div_pipe #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 17,
  parameter int QW    = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] den,
  input  sbe_pkg::side_t   in_side,
  output logic             out_valid,
  output logic [QW-1:0]    out_quot,
  output sbe_pkg::side_t   out_side
);
  import sbe_pkg::*;

  logic             vld_r  [QW];
  logic [DEN_W-1:0] rem_r  [QW];
  logic [QW-1:0]    lo_r   [QW];
  logic [QW-1:0]    quot_r [QW];
  side_t            side_r [QW];

  logic             src_vld  [QW];
  logic [DEN_W-1:0] src_rem  [QW];
  logic [QW-1:0]    src_lo   [QW];
  logic [QW-1:0]    src_quot [QW];
  side_t            src_side [QW];

  // restoring division, one quotient bit per stage; the numerator must be
  // below den << QW, which holds for every item that is later used
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign src_vld[k]  = in_valid;
      assign src_rem[k]  = DEN_W'(in_num >> QW);
      assign src_lo[k]   = in_num[QW-1:0];
      assign src_quot[k] = '0;
      assign src_side[k] = in_side;
    end else begin : g_next
      assign src_vld[k]  = vld_r[k-1];
      assign src_rem[k]  = rem_r[k-1];
      assign src_lo[k]   = lo_r[k-1];
      assign src_quot[k] = quot_r[k-1];
      assign src_side[k] = side_r[k-1];
    end

    assign sh   = {src_rem[k], src_lo[k][QW-1]};
    assign ge   = (sh >= {1'b0, den});
    assign diff = sh - {1'b0, den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        lo_r[k]   <= {src_lo[k][QW-2:0], 1'b0};
        quot_r[k] <= {src_quot[k][QW-2:0], ge};
        side_r[k] <= src_side[k];
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quot  = quot_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

FILE: sv/soft_brush_erase_pixel_blend_top.sv
// Channel   Dir  Kind                Content
// in_ch     in   valid/ready stream  dab center, pressure, pixel coords, RGBA
// out_ch    out  valid/ready stream  blended RGBA, touched flag
// cfg       in   APB-style, 4b addr  dab size, opacity, hardness
//
// One transaction per cycle sustained while the output is not stalled; the path runs
// through stages A-C, the 25-stage square-root pipe and the two bit-per-stage divider pipes.
// Reset (rst_n, synchronous) clears all stage valid bits and loads the
// register defaults. A stalled output freezes the whole pipe at once;
// nothing is dropped or repeated.
`include "assert_macros.svh"

module soft_brush_erase_pixel_blend_top #(
  parameter int MAX_LAYER_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  sbe_in_if.sink      in_ch,
  sbe_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sbe_pkg::*;

  localparam int RT_W = 25;
  localparam int RAD_W = SIZE_W - 1;

  // ---------------- configuration ----------------
  logic [SIZE_W-1:0]  size_r;
  logic [PCT_W-1:0]   opac_r;
  logic [PCT_W-1:0]   hard_r;
  logic [RAD_W-1:0]   radius_r;
  logic [2*RAD_W-1:0] rsq_r;
  logic [Q_W-1:0]     o_q_r;
  logic [Q_W-1:0]     h_q_r;
  logic               cfg_wr;
  logic [RAD_W-1:0]   wr_radius;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign wr_radius = pwdata[SIZE_W-1:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= 10'd20;
      opac_r   <= 7'd100;
      hard_r   <= 7'd50;
      radius_r <= 9'd10;
      rsq_r    <= 18'd100;
      o_q_r    <= Q_ONE;
      h_q_r    <= 17'd32768;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_DAB_SIZE: begin
          size_r   <= pwdata[SIZE_W-1:0];
          radius_r <= wr_radius;
          rsq_r    <= 18'(wr_radius) * 18'(wr_radius);
        end
        REG_OPACITY: begin
          opac_r <= pwdata[PCT_W-1:0];
          o_q_r  <= pct_to_q(pwdata[PCT_W-1:0]);
        end
        REG_HARDNESS: begin
          hard_r <= pwdata[PCT_W-1:0];
          h_q_r  <= pct_to_q(pwdata[PCT_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_DAB_SIZE:   prdata = 32'(size_r);
      REG_OPACITY:    prdata = 32'(opac_r);
      REG_HARDNESS:   prdata = 32'(hard_r);
      default:        prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic o_vld_r;

  // freeze every stage while the output transaction waits
  assign en          = !o_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage A: offsets, bounds, pressure
  logic                a_vld_r;
  logic signed [14:0]  a_dx_r;
  logic signed [14:0]  a_dy_r;
  logic                a_inb_r;
  logic [Q_W-1:0]      a_p_r;
  pix_t                a_pix_r;

  // stage B: squares, pressure * opacity
  logic                b_vld_r;
  logic [27:0]         b_dx2_r;
  logic [27:0]         b_dy2_r;
  logic                b_inb_r;
  logic [33:0]         b_po_r;
  pix_t                b_pix_r;
  logic signed [29:0]  dx_sq;
  logic signed [29:0]  dy_sq;

  // stage C: distance test
  logic                c_vld_r;
  logic [2*RT_W-1:0]   c_val_r;
  side_t               c_side_r;
  logic [28:0]         dsq;

  // sqrt and divider wiring
  logic                sq_vld;
  logic [RT_W-1:0]     sq_root;
  side_t               sq_side;
  logic                d1_vld;
  logic [Q_W-1:0]      d1_quot;
  side_t               d1_side;
  logic                d2_vld;
  logic [Q_W-2:0]      d2_quot;
  side_t               d2_side;
  logic [Q_W-1:0]      h_den;

  // mid stage: normalized distance to falloff numerator
  logic                m_vld_r;
  logic [32:0]         m_num_r;
  side_t               m_side_r;
  logic [Q_W-1:0]      nd;
  logic                fall_on;
  logic [Q_W-1:0]      nd_over;

  // strength stage
  logic                s_vld_r;
  logic [17:0]         s_raw_r;
  side_t               s_side_r;
  logic [Q_W-1:0]      falloff;
  logic [33:0]         s_prod;

  // output stage
  logic [Q_W-1:0]      s_sat;
  logic [Q_W-1:0]      s_inv;
  logic [24:0]         bl_r;
  logic [24:0]         bl_g;
  logic [24:0]         bl_b;
  logic [24:0]         white;
  logic [CH_W-1:0]     o_red_r;
  logic [CH_W-1:0]     o_green_r;
  logic [CH_W-1:0]     o_blue_r;
  logic [CH_W-1:0]     o_alpha_r;
  logic                o_touch_r;

  // ---------------- stage A ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx_r  <= $signed({3'b000, in_ch.pixel_x}) - $signed({in_ch.center_x[13], in_ch.center_x});
      a_dy_r  <= $signed({3'b000, in_ch.pixel_y}) - $signed({in_ch.center_y[13], in_ch.center_y});
      a_inb_r <= (32'(in_ch.pixel_x) < MAX_LAYER_DIM) && (32'(in_ch.pixel_y) < MAX_LAYER_DIM);
      a_p_r   <= pres_to_q(in_ch.pen_pressure);
      a_pix_r <= '{red: in_ch.old_red, green: in_ch.old_green,
                   blue: in_ch.old_blue, alpha: in_ch.old_alpha};
    end
  end

  // ---------------- stage B ----------------
  assign dx_sq = 30'(a_dx_r) * 30'(a_dx_r);
  assign dy_sq = 30'(a_dy_r) * 30'(a_dy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_dx2_r <= dx_sq[27:0];
      b_dy2_r <= dy_sq[27:0];
      b_inb_r <= a_inb_r;
      b_po_r  <= 34'(a_p_r) * 34'(o_q_r);
      b_pix_r <= a_pix_r;
    end
  end

  // ---------------- stage C ----------------
  assign dsq = {1'b0, b_dx2_r} + {1'b0, b_dy2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  // a hit keeps the squared distance within 18 bits
  always_ff @(posedge clk) begin
    if (en) begin
      c_val_r      <= {dsq[17:0], 32'd0};
      c_side_r.hit <= b_inb_r && (dsq <= {11'd0, rsq_r});
      c_side_r.pix <= b_pix_r;
      c_side_r.po  <= b_po_r[32:16];
    end
  end

  // ---------------- distance ----------------
  sbe_sqrt_pipe #(
    .RW (RT_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_vld_r),
    .in_value  (c_val_r),
    .in_side   (c_side_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  sbe_div_pipe #(
    .NUM_W (RT_W),
    .DEN_W (RAD_W),
    .QW    (Q_W)
  ) u_div_rad (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_vld),
    .in_num    (sq_root),
    .den       (radius_r),
    .in_side   (sq_side),
    .out_valid (d1_vld),
    .out_quot  (d1_quot),
    .out_side  (d1_side)
  );

  // ---------------- falloff numerator ----------------
  assign nd      = (radius_r == '0) ? '0 : d1_quot;
  assign fall_on = (h_q_r < Q_ONE) && (nd > h_q_r);
  assign nd_over = nd - h_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_num_r  <= fall_on ? {nd_over, 16'd0} : '0;
      m_side_r <= d1_side;
    end
  end

  assign h_den = H_DEN_BASE - h_q_r;

  sbe_div_pipe #(
    .NUM_W (33),
    .DEN_W (Q_W),
    .QW    (Q_W - 1)
  ) u_div_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (m_vld_r),
    .in_num    (m_num_r),
    .den       (h_den),
    .in_side   (m_side_r),
    .out_valid (d2_vld),
    .out_quot  (d2_quot),
    .out_side  (d2_side)
  );

  // ---------------- strength ----------------
  // the quotient stays below one, so the falloff never clamps at zero
  assign falloff = Q_ONE - {1'b0, d2_quot};
  assign s_prod  = 34'(d2_side.po) * 34'(falloff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (en) begin
      s_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_raw_r  <= s_prod[33:16];
      s_side_r <= d2_side;
    end
  end

  // ---------------- blend toward white ----------------
  assign s_sat = (s_raw_r > 18'(Q_ONE)) ? Q_ONE : s_raw_r[Q_W-1:0];
  assign s_inv = Q_ONE - s_sat;
  assign white = 25'(s_sat) * 25'd255;
  assign bl_r  = 25'(s_side_r.pix.red)   * 25'(s_inv) + white;
  assign bl_g  = 25'(s_side_r.pix.green) * 25'(s_inv) + white;
  assign bl_b  = 25'(s_side_r.pix.blue)  * 25'(s_inv) + white;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= s_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_touch_r <= s_side_r.hit;
      if (s_side_r.hit) begin
        o_red_r   <= bl_r[23:16];
        o_green_r <= bl_g[23:16];
        o_blue_r  <= bl_b[23:16];
        o_alpha_r <= 8'hFF;
      end else begin
        o_red_r   <= s_side_r.pix.red;
        o_green_r <= s_side_r.pix.green;
        o_blue_r  <= s_side_r.pix.blue;
        o_alpha_r <= s_side_r.pix.alpha;
      end
    end
  end

  assign out_ch.valid     = o_vld_r;
  assign out_ch.new_red   = o_red_r;
  assign out_ch.new_green = o_green_r;
  assign out_ch.new_blue  = o_blue_r;
  assign out_ch.new_alpha = o_alpha_r;
  assign out_ch.touched   = o_touch_r;

  // ---------------- checks ----------------
  `SBE_ASSERT(a_touch_alpha, out_ch.valid && out_ch.touched |-> out_ch.new_alpha == 8'hFF, "alpha")
  `SBE_ASSERT(a_strength_range, s_vld_r |-> s_raw_r <= 18'(Q_ONE), "erase strength above one")
  `SBE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_ch.valid, "output valid right after reset")

endmodule

FILE: verif/tb_top.sv
module tb_top;
  import sbe_pkg::*;

  typedef struct {
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic [PRES_W-1:0]       pres;
    logic [PIX_W-1:0]        px;
    logic [PIX_W-1:0]        py;
    logic [CH_W-1:0]         r, g, b, a;
  } dab_px_t;

  typedef struct {
    logic [CH_W-1:0] r, g, b, a;
    logic            touched;
  } blend_px_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sbe_in_if  in_ch();
  sbe_out_if out_ch();

  soft_brush_erase_pixel_blend_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // shadow copy of the brush registers
  logic [SIZE_W-1:0] dab_size = 10'd20;
  logic [PCT_W-1:0]  opacity_pct = 7'd100;
  logic [PCT_W-1:0]  hardness_pct = 7'd50;

  dab_px_t   pixels_to_send[$];
  blend_px_t blended_due[$];
  int        send_idle_pct = 35;
  int        recv_idle_pct = 57;
  int        errors = 0;
  int        cycle_cnt = 0;
  logic      hold_go = 1'b0;
  int        hold_left = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res = 0;
    longint unsigned bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned pct_q(input logic [PCT_W-1:0] pct);
    longint unsigned p = (pct > 100) ? 100 : pct;
    return p * 65536 / 100;
  endfunction

  function automatic blend_px_t erase_blend(input dab_px_t d);
    blend_px_t res;
    longint dx, dy;
    longint unsigned rad, dsq, nd, h, o, p, f, q, s;
    logic [CH_W-1:0] chan[3];
    chan[0] = d.r; chan[1] = d.g; chan[2] = d.b;
    rad = dab_size / 2;
    dx = longint'(d.px) - longint'(d.cx);
    dy = longint'(d.py) - longint'(d.cy);
    dsq = dx * dx + dy * dy;
    res.touched = (d.px < 4096) && (d.py < 4096) && (dsq <= rad * rad);
    res.a = d.a;
    if (res.touched) begin
      nd = (rad > 0) ? int_sqrt(dsq << 32) / rad : 0;
      h = pct_q(hardness_pct);
      o = pct_q(opacity_pct);
      p = longint'(d.pres) * 65536 / 255;
      f = 65536;
      if (h < 65536 && nd > h) begin
        q = (nd - h) * 65536 / (65536 - h + 66);
        f = (q >= 65536) ? 0 : 65536 - q;
      end
      s = (((p * o) >> 16) * f) >> 16;
      if (s > 65536) s = 65536;
      for (int i = 0; i < 3; i++)
        chan[i] = 8'((longint'(chan[i]) * (65536 - s) + 255 * s) >> 16);
      res.a = 8'hFF;
    end
    res.r = chan[0]; res.g = chan[1]; res.b = chan[2];
    return res;
  endfunction

  // input driver
  always @(posedge clk) begin
    dab_px_t d;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        d.cx = in_ch.center_x; d.cy = in_ch.center_y; d.pres = in_ch.pen_pressure;
        d.px = in_ch.pixel_x; d.py = in_ch.pixel_y;
        d.r = in_ch.old_red; d.g = in_ch.old_green; d.b = in_ch.old_blue;
        d.a = in_ch.old_alpha;
        blended_due.insert(blended_due.size(), erase_blend(d));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pixels_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          d = pixels_to_send.pop_front();
          in_ch.center_x <= d.cx; in_ch.center_y <= d.cy;
          in_ch.pen_pressure <= d.pres;
          in_ch.pixel_x <= d.px; in_ch.pixel_y <= d.py;
          in_ch.old_red <= d.r; in_ch.old_green <= d.g;
          in_ch.old_blue <= d.b; in_ch.old_alpha <= d.a;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.center_x = '0; in_ch.center_y = '0; in_ch.pen_pressure = '0;
    in_ch.pixel_x = '0; in_ch.pixel_y = '0;
    in_ch.old_red = '0; in_ch.old_green = '0; in_ch.old_blue = '0; in_ch.old_alpha = '0;
    out_ch.ready = 1'b0;
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_go) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk) begin
    blend_px_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (blended_due.size() == 0) begin
          $error("unexpected transaction on result channel");
          errors++;
        end else begin
          want = blended_due.pop_front();
          if (out_ch.new_red !== want.r) begin
            $error("new_red: expected %0d, got %0d", want.r, out_ch.new_red); errors++;
          end
          if (out_ch.new_green !== want.g) begin
            $error("new_green: expected %0d, got %0d", want.g, out_ch.new_green); errors++;
          end
          if (out_ch.new_blue !== want.b) begin
            $error("new_blue: expected %0d, got %0d", want.b, out_ch.new_blue); errors++;
          end
          if (out_ch.new_alpha !== want.a) begin
            $error("new_alpha: expected %0d, got %0d", want.a, out_ch.new_alpha); errors++;
          end
          if (out_ch.touched !== want.touched) begin
            $error("touched: expected %0d, got %0d", want.touched, out_ch.touched);
            errors++;
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 400000) begin
      $display("soft_brush_erase_pixel_blend_top regression: fail");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 4'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_DAB_SIZE: dab_size = val[SIZE_W-1:0];
      REG_OPACITY:  opacity_pct = val[PCT_W-1:0];
      REG_HARDNESS: hardness_pct = val[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic add_pixel(input int cx, input int cy, input int pres,
                           input int px, input int py, input logic [31:0] rgba);
    dab_px_t d;
    d.cx = 14'(cx); d.cy = 14'(cy); d.pres = 8'(pres);
    d.px = 12'(px); d.py = 12'(py);
    {d.r, d.g, d.b, d.a} = rgba;
    pixels_to_send.insert(pixels_to_send.size(), d);
  endtask

  function automatic int clamp_pix(input int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  task automatic add_random_pixels(input int n);
    int cx, cy, off;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) begin
        add_pixel($signed(14'($urandom)), $signed(14'($urandom)), $urandom_range(255),
                  $urandom_range(4095), $urandom_range(4095), $urandom);
      end else begin
        cx = $urandom_range(4095);
        cy = $urandom_range(4095);
        off = dab_size / 2 + 2;
        add_pixel(cx, cy, ($urandom_range(9) == 0) ? 255 * $urandom_range(1) : $urandom_range(255),
                  clamp_pix(cx + $urandom_range(2 * off) - off),
                  clamp_pix(cy + $urandom_range(2 * off) - off), $urandom);
      end
    end
  endtask

  task automatic drain();
    while (pixels_to_send.size() > 0 || in_ch.valid || blended_due.size() > 0)
      @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  initial begin
    int cfg[6][3] = '{'{20, 100, 50}, '{1, 100, 0}, '{1000, 127, 100},
                      '{0, 0, 127}, '{37, 55, 33}, '{1023, 100, 0}};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(REG_DAB_SIZE, cfg[ph][0]);
      reg_write(REG_OPACITY, cfg[ph][1]);
      reg_write(REG_HARDNESS, cfg[ph][2]);
      send_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 57 : 0;
      recv_idle_pct = (ph < 2) ? 57 : (ph < 4) ? 35 : 0;
      if (ph == 0) begin
        // center, rim, just outside, extremes of coordinates and colors
        add_pixel(100, 100, 255, 100, 100, 32'h00000000);
        add_pixel(100, 100, 255, 110, 100, 32'hFFFFFFFF);
        add_pixel(100, 100, 255, 111, 100, 32'h12345678);
        add_pixel(100, 100, 0, 105, 105, 32'h80808080);
        add_pixel(100, 100, 128, 107, 107, 32'h7F7F7F7F);
        add_pixel(-8192, -8192, 255, 0, 0, 32'hAAAAAAAA);
        add_pixel(8191, 8191, 255, 4095, 4095, 32'h55555555);
        add_pixel(-5, 0, 200, 0, 0, 32'h01020304);
        add_pixel(0, 0, 255, 0, 0, 32'hFF00FF00);
        add_pixel(4095, 4095, 1, 4095, 4095, 32'h00FF00FF);
        add_pixel(4100, 4095, 254, 4095, 4095, 32'hF0F0F0F0);
        add_pixel(2000, 2000, 255, 2006, 2008, 32'h0F0F0F0F);
        add_pixel(2000, 2000, 255, 2003, 2004, 32'h10203040);
      end else if (ph == 1 || ph == 3) begin
        // zero radius: only the center pixel is hit
        add_pixel(500, 600, 255, 500, 600, 32'h20406080);
        add_pixel(500, 600, 255, 501, 600, 32'h20406080);
      end else if (ph == 2) begin
        add_pixel(0, 0, 255, 499, 0, 32'h00000000);
        add_pixel(-8192, 8191, 255, 0, 4095, 32'h11111111);
      end
      if (ph == 1) begin
        fork
          add_random_pixels(92);
          begin
            repeat (30) @(negedge clk);
            hold_go = 1'b1;
            @(negedge clk);
            hold_go = 1'b0;
          end
        join
      end else begin
        add_random_pixels(92);
      end
      drain();
    end
    if (errors == 0) begin
      $display("soft_brush_erase_pixel_blend_top regression: pass");
    end else begin
      $display("soft_brush_erase_pixel_blend_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: soft_brush_erase_pixel_blend_top.f
+incdir+sv
sv/sbe_pkg.sv
sv/sbe_in_if.sv
sv/sbe_out_if.sv
sv/sbe_sqrt_pipe.sv
sv/sbe_div_pipe.sv
sv/soft_brush_erase_pixel_blend_top.sv
verif/tb_top.sv
